@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL that carries concurrent checks (kmeans_nearest_centre).
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication checked in the same cycle outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/kmn_pkg.sv @@
// Package for the k-means nearest centre block: field widths, codes,
// beat payload types and the controller/datapath command and status types.
package kmn_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int MAX_BANDS_DEF   = 16;
  localparam int SAMPLE_BITS     = 16;
  localparam int CFG_BITS        = 5;
  localparam int INDEX_BITS      = 4;
  localparam int LABEL_BITS      = 5;
  localparam int DIST_BITS       = 36;
  localparam int SQ_BITS         = 2 * SAMPLE_BITS;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] CLASS_COUNT_RST = CFG_BITS'(2);
  localparam logic [CFG_BITS-1:0] BAND_COUNT_RST  = CFG_BITS'(1);

  // Configuration register indexes.
  localparam logic CFG_CLASS_COUNT = 1'b0;
  localparam logic CFG_BAND_COUNT  = 1'b1;

  // Input beat command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [INDEX_BITS-1:0]  class_index;
    logic [INDEX_BITS-1:0]  band_index;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   pixel_ok;
  } kmn_in_t;

  typedef struct packed {
    logic [LABEL_BITS-1:0] label;
    logic [DIST_BITS-1:0]  min_distance;
  } kmn_out_t;

  typedef struct packed {
    logic load;     // write the beat's coordinate into the centre store
    logic start;    // latch a pixel sample and rewind the class counter
    logic issue;    // send the current class into the distance pipeline
    logic advance;  // move on to the next band of the pixel
    logic finish;   // register the result and clear the pixel state
  } kmn_cmd_t;

  typedef struct packed {
    logic last_class;
    logic last_band;
    logic pipe_busy;
  } kmn_status_t;

endpackage

@@ rtl/kmn_ctrl.sv @@
// Controller of the k-means nearest centre block: sequences accept, class
// passes, pipeline drain and result hand-off. Depends on kmn_pkg.
module kmn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  input  logic                 out_ready_i,
  input  kmn_pkg::kmn_status_t status_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output kmn_pkg::kmn_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == kmn_pkg::CMD_PIXEL) begin
            cmd_o.start = 1'b1;
            state_d     = S_RUN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_class) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          if (!status_i.last_band) begin
            cmd_o.advance = 1'b1;
            state_d       = S_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            // The pass waits here until the output register is free.
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/kmn_datapath.sv @@
// Datapath of the k-means nearest centre block: configuration registers,
// centre and distance stores, squared-difference pipeline and result register.
// Depends on kmn_pkg.
module kmn_datapath #(
  parameter int MAX_CLASSES = kmn_pkg::MAX_CLASSES_DEF,
  parameter int MAX_BANDS   = kmn_pkg::MAX_BANDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [kmn_pkg::CFG_BITS-1:0]  cfg_data_i,
  input  kmn_pkg::kmn_in_t              in_data_i,
  input  kmn_pkg::kmn_cmd_t             cmd_i,
  output kmn_pkg::kmn_status_t          status_o,
  output kmn_pkg::kmn_out_t             out_data_o
);

  localparam int CIW       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int BIW       = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int CEN_DEPTH = MAX_CLASSES * MAX_BANDS;
  localparam int AW        = (CEN_DEPTH > 1) ? $clog2(CEN_DEPTH) : 1;
  localparam int CCW       = ((CIW + 1) > kmn_pkg::CFG_BITS) ? CIW + 1 : kmn_pkg::CFG_BITS;
  localparam int BCW       = ((BIW + 1) > kmn_pkg::CFG_BITS) ? BIW + 1 : kmn_pkg::CFG_BITS;
  localparam int SB        = kmn_pkg::SAMPLE_BITS;
  localparam int DB        = kmn_pkg::DIST_BITS;
  localparam int QB        = kmn_pkg::SQ_BITS;

  // Configuration registers.
  logic [kmn_pkg::CFG_BITS-1:0] class_count_q, band_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= kmn_pkg::CLASS_COUNT_RST;
      band_count_q  <= kmn_pkg::BAND_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kmn_pkg::CFG_CLASS_COUNT: class_count_q <= cfg_data_i;
        kmn_pkg::CFG_BAND_COUNT:  band_count_q  <= cfg_data_i;
      endcase
    end
  end

  // Last class and last band indexes after clamping the counts to 1..MAX.
  logic [CCW-1:0] cc_ext, class_last;
  logic [BCW-1:0] bc_ext, band_last;

  always_comb begin
    cc_ext = CCW'(class_count_q);
    if (cc_ext == '0) begin
      class_last = '0;
    end else if (cc_ext > CCW'(MAX_CLASSES)) begin
      class_last = CCW'(MAX_CLASSES - 1);
    end else begin
      class_last = cc_ext - CCW'(1);
    end
    bc_ext = BCW'(band_count_q);
    if (bc_ext == '0) begin
      band_last = '0;
    end else if (bc_ext > BCW'(MAX_BANDS)) begin
      band_last = BCW'(MAX_BANDS - 1);
    end else begin
      band_last = bc_ext - BCW'(1);
    end
  end

  // Pixel control state.
  logic [CIW-1:0]         cls_cnt_q, cls_cnt_d;
  logic [BIW-1:0]         pos_q, pos_d;
  logic                   bad_q, bad_d;
  logic [MAX_CLASSES-1:0] sum_vld_q, sum_vld_d;
  logic                   v1_q, v2_q, v3_q;

  // Pipeline payload.
  logic [SB-1:0]  sample_q;
  logic [SB-1:0]  cen_rd_q;
  logic [DB-1:0]  sum_rd_q;
  logic           vld1_q;
  logic [CIW-1:0] j1_q, j2_q, j3_q;
  logic [SB-1:0]  diff2_q;
  logic [DB-1:0]  sum2_q, sum3_q;
  logic [QB-1:0]  sq3_q;
  logic [CIW-1:0] best_q;
  logic [DB-1:0]  best_d_q;
  kmn_pkg::kmn_out_t out_q;

  logic [SB-1:0] centre_mem [CEN_DEPTH];
  logic [DB-1:0] sum_mem [MAX_CLASSES];

  logic          load_ok;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [SB-1:0] diff1;
  logic [DB:0]   total3;
  logic [DB-1:0] new_sum3;

  assign load_ok = (int'(in_data_i.class_index) < MAX_CLASSES) &&
                   (int'(in_data_i.band_index) < MAX_BANDS);
  assign wr_addr = AW'(int'(in_data_i.class_index) * MAX_BANDS + int'(in_data_i.band_index));
  assign rd_addr = AW'(int'(cls_cnt_q) * MAX_BANDS + int'(pos_q));

  // Centre store: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      centre_mem[wr_addr] <= in_data_i.sample;
    end
    if (cmd_i.issue) begin
      cen_rd_q <= centre_mem[rd_addr];
      sum_rd_q <= sum_mem[cls_cnt_q];
    end
    if (v3_q) begin
      sum_mem[j3_q] <= new_sum3;
    end
  end

  assign diff1 = (sample_q >= cen_rd_q) ? (sample_q - cen_rd_q) : (cen_rd_q - sample_q);

  // Saturating accumulate: the sum may not pass the 36-bit ceiling.
  always_comb begin
    total3 = {1'b0, sum3_q} + (DB + 1)'(sq3_q);
    if (total3 > {1'b0, kmn_pkg::DIST_MAX}) begin
      new_sum3 = kmn_pkg::DIST_MAX;
    end else begin
      new_sum3 = total3[DB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sample_q <= in_data_i.sample;
    end
    j1_q    <= cls_cnt_q;
    vld1_q  <= sum_vld_q[cls_cnt_q];
    diff2_q <= diff1;
    sum2_q  <= vld1_q ? sum_rd_q : '0;
    j2_q    <= j1_q;
    sq3_q   <= QB'(diff2_q) * QB'(diff2_q);
    sum3_q  <= sum2_q;
    j3_q    <= j2_q;
    // Class 0 opens every pass, so it seeds the running minimum.
    if (v3_q && ((j3_q == '0) || (new_sum3 < best_d_q))) begin
      best_q   <= j3_q;
      best_d_q <= new_sum3;
    end
    if (cmd_i.finish) begin
      if (bad_q) begin
        out_q.label        <= '0;
        out_q.min_distance <= '0;
      end else begin
        out_q.label        <= kmn_pkg::LABEL_BITS'(int'(best_q) + 1);
        out_q.min_distance <= best_d_q;
      end
    end
  end

  always_comb begin
    cls_cnt_d = cls_cnt_q;
    pos_d     = pos_q;
    bad_d     = bad_q;
    sum_vld_d = sum_vld_q;
    if (cmd_i.start) begin
      cls_cnt_d = '0;
      if (!in_data_i.pixel_ok) begin
        bad_d = 1'b1;
      end
    end
    if (cmd_i.issue) begin
      cls_cnt_d = cls_cnt_q + CIW'(1);
    end
    if (v3_q) begin
      sum_vld_d[j3_q] = 1'b1;
    end
    if (cmd_i.advance) begin
      pos_d = pos_q + BIW'(1);
    end
    if (cmd_i.finish) begin
      pos_d     = '0;
      bad_d     = 1'b0;
      sum_vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_cnt_q <= '0;
      pos_q     <= '0;
      bad_q     <= 1'b0;
      sum_vld_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else begin
      cls_cnt_q <= cls_cnt_d;
      pos_q     <= pos_d;
      bad_q     <= bad_d;
      sum_vld_q <= sum_vld_d;
      v1_q      <= cmd_i.issue;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
    end
  end

  assign status_o.last_class = (CCW'(cls_cnt_q) == class_last);
  assign status_o.last_band  = (BCW'(pos_q) >= band_last);
  assign status_o.pipe_busy  = v1_q | v2_q | v3_q;
  assign out_data_o          = out_q;

endmodule

@@ rtl/kmeans_nearest_centre.sv @@
// K-means assignment step: labels each multiband pixel with its nearest centre.
// Input channel (in_valid_i/in_ready_o/in_data_i): a beat with cmd = load writes
// one centre coordinate; a beat with cmd = pixel carries one band
// sample of a pixel. Centres must be loaded before pixels read them.
// A pixel beat is accepted while idle; then each class in turn goes through the
// shared squared-difference and accumulate pipeline, followed by a three-stage
// drain and the step to the next band or the pixel's finish; no further beat is taken meanwhile.
// After the last band of a pixel one result beat (label, min_distance) appears on
// the output channel from the output register after the drain; label 0 marks a bad pixel.
// The result sits in an output register, so the next pixel's bands are taken
// while it waits. If the receiver still holds the previous result when a pixel
// finishes, the block holds that pixel's end and takes no input until the
// register frees up.
// Configuration (cfg_we_i/cfg_index_i/cfg_data_i) is for the user to write only
// while idle; the block itself does not enforce it. Reset sets class_count to 2,
// band_count to 1 and clears all pixel state; the centre store holds no defined value until it is loaded.
// Depends on kmn_pkg, kmn_ctrl, kmn_datapath and assert_macros.svh.
`include "assert_macros.svh"

module kmeans_nearest_centre #(
  parameter int MAX_CLASSES = kmn_pkg::MAX_CLASSES_DEF,
  parameter int MAX_BANDS   = kmn_pkg::MAX_BANDS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [kmn_pkg::CFG_BITS-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  kmn_pkg::kmn_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output kmn_pkg::kmn_out_t            out_data_o
);

  kmn_pkg::kmn_cmd_t    cmd;
  kmn_pkg::kmn_status_t status;

  kmn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  kmn_datapath #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_BANDS   (MAX_BANDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

  // A new beat is only taken once the previous pass has fully drained.
  `ASSERT_IMPLIES(a_ready_drained, clk_i, rst_ni, in_ready_o, !status.pipe_busy, "ready while pipeline busy")
  // A finishing pixel never overwrites a result the receiver has not taken.
  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, cmd.finish, (!out_valid_o || out_ready_i), "result overwritten")
  // A result is only produced after the last band with all sums written back.
  `ASSERT_IMPLIES(a_finish_ok, clk_i, rst_ni, cmd.finish, (status.last_band && !status.pipe_busy), "early finish")
  // The controller issues at most one command per cycle.
  `ASSERT_HOLDS(a_one_cmd, clk_i, rst_ni, $onehot0({cmd.load, cmd.start, cmd.issue, cmd.advance, cmd.finish}), "multiple commands")

endmodule
